// ===== rtl/dfawc_pkg.sv =====
package dfawc_pkg;

	localparam int MAX_STATES_DEF = 64;
	localparam int ALPHABET_SIZE_DEF = 26;
	localparam int COUNT_W = 30;
	localparam logic [COUNT_W-1:0] COUNT_MOD = 30'd1000000007;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_MARK  = 2'd1,
		MODE_RUN   = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RA_RD,
		ST_RA_EV,
		ST_RA_END,
		ST_US_RD,
		ST_US_EV,
		ST_US_END,
		ST_CI,
		ST_PL_ROW,
		ST_PL_ROWD,
		ST_PL_TAB,
		ST_PL_EV,
		ST_PL_ADD,
		ST_PL_END,
		ST_SM_RD,
		ST_SM_EV,
		ST_DONE
	} state_t;

	// Modular add of two reduced counts.
	function automatic logic [COUNT_W-1:0] add_mod(input logic [COUNT_W-1:0] a,
			input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, COUNT_MOD})
			s = s - {1'b0, COUNT_MOD};
		return s[COUNT_W-1:0];
	endfunction

endpackage

// ===== rtl/dfawc_ram.sv =====
module dfawc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/dfa_finite_language_word_count_unit.sv =====
// Counts the words accepted by a loaded deterministic automaton. Load and mark
// items are taken in the idle state. Reset and a clear-all item start a
// clearing pass over all MAX_STATES*ALPHABET_SIZE entries of the transition
// memory (1664 by default) during which no item is accepted. A run item walks
// the transition memory, reading and then evaluating each entry, in passes
// over the n*ALPHABET_SIZE entries of the states in use: backward reach passes
// and forward reach passes, each repeated until nothing changes, then a pass
// over the n states to set up the counts, then one peeling pass per
// topological level (with a row read of the count memory and an add step for
// each counted edge), then a read and an add step per state to sum the counts.
// A run gives one result; the result register lets the next item in while it waits.
module dfa_finite_language_word_count_unit
	import dfawc_pkg::*;
#(
	parameter int MAX_STATES = MAX_STATES_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,   // states_in_use
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // from_state[5:0], to_state[11:6], letter[16:12]
	input  logic [1:0]  s_tuser,    // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // word_count[29:0]
	output logic        m_tuser     // infinite
);

	localparam int SW = $clog2(MAX_STATES);
	localparam int NW = $clog2(MAX_STATES + 1);
	localparam int CW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int TDEPTH = MAX_STATES * ALPHABET_SIZE;
	localparam int AW = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

	state_t state_q, state_d;

	logic [6:0]         cfg_q;
	logic [NW-1:0]      n;
	logic [SW-1:0]      n_last;
	logic [MAX_STATES-1:0] n_mask;

	logic [SW-1:0] s_q;
	logic [CW-1:0] c_q;
	logic [AW-1:0] base_q, clr_q;
	logic          row_last, sweep_last;

	logic [MAX_STATES-1:0] acc_q, ra_q, us_q, rm_q, fr_q, hin_q;
	logic                  chg_q, inf_q;
	logic [SW-1:0]         t_q;
	logic [COUNT_W-1:0]    cur_q, tot_q;

	logic               m_valid_q, m_inf_q;
	logic [COUNT_W-1:0] m_count_q;

	mode_t       in_mode;
	logic [5:0]  in_from, in_to;
	logic [4:0]  in_letter;
	logic        load_ok, mark_ok;
	logic [AW-1:0] load_addr;

	logic          tab_we;
	logic [AW-1:0] tab_waddr, tab_raddr;
	logic [6:0]    tab_wdata, tab_rdata;
	logic          t_ok;
	logic [SW-1:0] ti;

	logic               cnt_we;
	logic [SW-1:0]      cnt_waddr, cnt_raddr;
	logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;

	logic step, step_row;

	assign cfg_ready = 1'b1;

	assign in_mode   = mode_t'(s_tuser);
	assign in_from   = s_tdata[5:0];
	assign in_to     = s_tdata[11:6];
	assign in_letter = s_tdata[16:12];
	assign mark_ok   = 32'(in_from) < MAX_STATES;
	assign load_ok   = mark_ok && (32'(in_letter) < ALPHABET_SIZE);
	assign load_addr = AW'(32'(in_from) * ALPHABET_SIZE + 32'(in_letter));

	always_comb begin
		if (cfg_q == '0)
			n = NW'(1);
		else if (32'(cfg_q) > MAX_STATES)
			n = NW'(MAX_STATES);
		else
			n = NW'(cfg_q);
		n_last = SW'(32'(n) - 1);
		for (int i = 0; i < MAX_STATES; i++)
			n_mask[i] = (i < 32'(n));
	end

	assign row_last   = (c_q == CW'(ALPHABET_SIZE - 1));
	assign sweep_last = row_last && (s_q == n_last);
	assign tab_raddr  = base_q + AW'(c_q);
	assign t_ok       = tab_rdata[6] && (32'(tab_rdata[5:0]) < 32'(n));
	assign ti         = SW'(tab_rdata[5:0]);

	dfawc_ram #(.WIDTH(7), .DEPTH(TDEPTH)) u_tab (
		.clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
		.raddr(tab_raddr), .rdata(tab_rdata)
	);

	dfawc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_STATES)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		tab_we    = 1'b0;
		tab_waddr = clr_q;
		tab_wdata = '0;
		cnt_we    = 1'b0;
		cnt_waddr = s_q;
		cnt_wdata = '0;
		cnt_raddr = s_q;
		step      = 1'b0;
		step_row  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (in_mode)
						MODE_LOAD: begin
							tab_we    = load_ok;
							tab_waddr = load_addr;
							tab_wdata = {1'b1, in_to};
						end
						MODE_MARK: ;
						MODE_RUN: state_d = ST_RA_RD;
						MODE_CLEAR: state_d = ST_CLEAR;
						default: ;
					endcase
				end
			end
			ST_CLEAR: begin
				tab_we = 1'b1;
				if (clr_q == AW'(TDEPTH - 1))
					state_d = ST_IDLE;
			end
			ST_RA_RD: state_d = ST_RA_EV;
			ST_RA_EV: begin
				step    = 1'b1;
				state_d = sweep_last ? ST_RA_END : ST_RA_RD;
			end
			ST_RA_END: begin
				if (chg_q)
					state_d = ST_RA_RD;
				else
					state_d = ra_q[0] ? ST_US_RD : ST_DONE;
			end
			ST_US_RD: state_d = ST_US_EV;
			ST_US_EV: begin
				step    = 1'b1;
				state_d = sweep_last ? ST_US_END : ST_US_RD;
			end
			ST_US_END: state_d = chg_q ? ST_US_RD : ST_CI;
			ST_CI: begin
				cnt_we    = 1'b1;
				cnt_wdata = (s_q == '0) ? COUNT_W'(1) : '0;
				step_row  = 1'b1;
				if (s_q == n_last)
					state_d = ST_PL_ROW;
			end
			ST_PL_ROW: state_d = ST_PL_ROWD;
			ST_PL_ROWD: state_d = ST_PL_TAB;
			ST_PL_TAB: state_d = ST_PL_EV;
			ST_PL_EV: begin
				if (t_ok && us_q[ti] && fr_q[s_q]) begin
					cnt_raddr = ti;
					state_d   = ST_PL_ADD;
				end else begin
					step = 1'b1;
					if (sweep_last)
						state_d = ST_PL_END;
					else
						state_d = row_last ? ST_PL_ROW : ST_PL_TAB;
				end
			end
			ST_PL_ADD: begin
				cnt_we    = 1'b1;
				cnt_waddr = t_q;
				cnt_wdata = add_mod(cnt_rdata, cur_q);
				step      = 1'b1;
				if (sweep_last)
					state_d = ST_PL_END;
				else
					state_d = row_last ? ST_PL_ROW : ST_PL_TAB;
			end
			ST_PL_END: begin
				// Done when nothing is left; a cycle when nothing could be removed.
				if ((rm_q & hin_q) == '0)
					state_d = ST_SM_RD;
				else if ((rm_q & ~hin_q) == '0)
					state_d = ST_DONE;
				else
					state_d = ST_PL_ROW;
			end
			ST_SM_RD: state_d = ST_SM_EV;
			ST_SM_EV: begin
				step_row = 1'b1;
				state_d  = (s_q == n_last) ? ST_DONE : ST_SM_RD;
			end
			ST_DONE: begin
				if (!m_valid_q || m_tready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q     <= 7'd1;
			s_q       <= '0;
			c_q       <= '0;
			base_q    <= '0;
			clr_q     <= '0;
			acc_q     <= '0;
			ra_q      <= '0;
			us_q      <= '0;
			rm_q      <= '0;
			fr_q      <= '0;
			hin_q     <= '0;
			chg_q     <= 1'b0;
			inf_q     <= 1'b0;
			t_q       <= '0;
			cur_q     <= '0;
			tot_q     <= '0;
			m_valid_q <= 1'b0;
			m_inf_q   <= 1'b0;
			m_count_q <= '0;
		end else begin
			if (cfg_valid)
				cfg_q <= cfg_data;

			if (step) begin
				if (row_last) begin
					c_q    <= '0;
					s_q    <= sweep_last ? '0 : s_q + SW'(1);
					base_q <= sweep_last ? '0 : base_q + AW'(ALPHABET_SIZE);
				end else begin
					c_q <= c_q + CW'(1);
				end
			end
			if (step_row)
				s_q <= (s_q == n_last) ? '0 : s_q + SW'(1);

			if (m_valid_q && m_tready && state_q != ST_DONE)
				m_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						case (in_mode)
							MODE_MARK: if (mark_ok) acc_q[SW'(in_from)] <= 1'b1;
							MODE_RUN: begin
								ra_q  <= acc_q & n_mask;
								chg_q <= 1'b0;
								inf_q <= 1'b0;
								tot_q <= '0;
							end
							MODE_CLEAR: begin
								acc_q <= '0;
								clr_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_RA_EV: begin
					if (t_ok && ra_q[ti] && !ra_q[s_q]) begin
						ra_q[s_q] <= 1'b1;
						chg_q     <= 1'b1;
					end
				end
				ST_RA_END: begin
					chg_q <= 1'b0;
					us_q  <= {{(MAX_STATES-1){1'b0}}, ra_q[0]};
				end
				ST_US_EV: begin
					if (us_q[s_q] && t_ok && ra_q[ti] && !us_q[ti]) begin
						us_q[ti] <= 1'b1;
						chg_q    <= 1'b1;
					end
				end
				ST_US_END: begin
					chg_q <= 1'b0;
					rm_q  <= us_q;
					fr_q  <= '0;
					hin_q <= '0;
				end
				ST_PL_ROWD: cur_q <= cnt_rdata;
				ST_PL_EV: begin
					t_q <= ti;
					if (t_ok && us_q[ti] && rm_q[s_q])
						hin_q[ti] <= 1'b1;
				end
				ST_PL_END: begin
					fr_q  <= rm_q & ~hin_q;
					rm_q  <= rm_q & hin_q;
					hin_q <= '0;
					if ((rm_q & hin_q) != '0 && (rm_q & ~hin_q) == '0)
						inf_q <= 1'b1;
				end
				ST_SM_EV: begin
					if (us_q[s_q] && acc_q[s_q])
						tot_q <= add_mod(tot_q, cnt_rdata);
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_inf_q   <= inf_q;
						m_count_q <= inf_q ? '0 : tot_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_count_q};
	assign m_tuser  = m_inf_q;

	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("infinite result carries a nonzero count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[29:0] < COUNT_MOD)
		else $error("count not reduced");

	a_useful_subset: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PL_END |-> (us_q & ~ra_q) == '0)
		else $error("useful state that cannot reach acceptance");

	a_peel_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PL_END |-> (fr_q & rm_q) == '0)
		else $error("removed level overlaps remaining states");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == MODE_RUN |=> state_q == ST_RA_RD && !chg_q)
		else $error("run did not start a reach pass");

endmodule
